>>> hdl/segregated_free_list_allocator_assert.svh
// Assertion macros for the segregated free-list allocator.
// Each macro expects clk and rst_n in scope.
`ifndef SEGREGATED_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define SEGREGATED_FREE_LIST_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge out of reset
`define SFLA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Antecedent in one cycle implies consequent in the next
`define SFLA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define SFLA_ASSERT(lbl, prop, msg)
`define SFLA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> hdl/sfla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfla_pkg
// Constants, codes and write-port types of the free-list allocator.
// ----------------------------------------------------------------------------
package sfla_pkg;

  localparam int REGION_BYTES    = 65536;
  localparam int NUM_CLASSES     = 16;
  localparam int ALIGN_BYTES     = 8;
  localparam int MAX_SMALL_BYTES = 128;

  localparam int ADDR_W   = 16;
  localparam int ALIGN_W  = $clog2(ALIGN_BYTES);
  localparam int CLS_W    = $clog2(NUM_CLASSES);
  localparam int LINK_AW  = $clog2(REGION_BYTES / ALIGN_BYTES);
  localparam int POOL_W   = $clog2(REGION_BYTES) + 1;
  localparam int GROW_W   = POOL_W + 1;
  localparam int SIZE_W   = $clog2(MAX_SMALL_BYTES + ALIGN_BYTES) + 1;
  localparam int REFILL_W = 6;

  localparam logic [REFILL_W-1:0] REFILL_RESET = REFILL_W'(20);
  localparam logic [REFILL_W-1:0] MAX_REFILL   = REFILL_W'(32);
  localparam int                  SHARE_SHIFT  = 4;
  localparam logic [ADDR_W-1:0]   EMPTY_MARK   = {ADDR_W{1'b1}};

  // op codes
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // status codes
  localparam logic [1:0] ST_GRANTED  = 2'd0;
  localparam logic [1:0] ST_RELEASED = 2'd1;
  localparam logic [1:0] ST_LARGE    = 2'd2;
  localparam logic [1:0] ST_OOM      = 2'd3;

  typedef struct packed {
    logic              en;
    logic [CLS_W-1:0]  addr;
    logic [ADDR_W-1:0] data;
  } heads_wr_t;

  typedef struct packed {
    logic               en;
    logic [LINK_AW-1:0] addr;
    logic [ADDR_W-1:0]  data;
  } links_wr_t;

endpackage

>>> hdl/sfla_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfla_if
// Request, response and config-write channels of the allocator.
// ----------------------------------------------------------------------------
interface sfla_req_if;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [sfla_pkg::ADDR_W-1:0] request_bytes;
  logic [sfla_pkg::ADDR_W-1:0] block_address;
  modport source (output valid, operation, request_bytes, block_address, input ready);
  modport sink   (input valid, operation, request_bytes, block_address, output ready);
endinterface

interface sfla_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [sfla_pkg::ADDR_W-1:0] granted_address;
  logic [1:0]                status;
  modport source (output valid, granted_address, status, input ready);
  modport sink   (input valid, granted_address, status, output ready);
endinterface

interface sfla_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sfla_pkg::REFILL_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> hdl/segregated_free_list_allocator.sv
`timescale 1ns / 1ps
// Item paths: release, head pop, large request, and refill, which carves
//   blocks; a pool grow may first return the pool remnant, and a borrow
//   scans the classes. The result beat is registered and is raised as
//   the sequencer returns to idle.
// Throughput: one item at a time; the sequencer around the two memories
//   sets the rate. Reset: synchronous active-low; lists, pool, region empty.
// ----------------------------------------------------------------------------
// segregated_free_list_allocator
// Small-object allocator with per-class free lists kept in a head memory
// and a link memory, refilled from a bump-allocated chunk pool.
// ----------------------------------------------------------------------------
`include "segregated_free_list_allocator_assert.svh"
module segregated_free_list_allocator (
  input  logic        clk,
  input  logic        rst_n,
  sfla_req_if.sink    in_req,
  sfla_rsp_if.source  out_rsp,
  sfla_cfg_if.sink    cfg_wr
);
  import sfla_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_PUSH_RD  = 4'd1;
  localparam logic [3:0] S_PUSH_WR  = 4'd2;
  localparam logic [3:0] S_ALLOC_RD = 4'd3;
  localparam logic [3:0] S_ALLOC_CK = 4'd4;
  localparam logic [3:0] S_POP_WR   = 4'd5;
  localparam logic [3:0] S_TAKE     = 4'd6;
  localparam logic [3:0] S_TAKE_END = 4'd7;
  localparam logic [3:0] S_GROW     = 4'd8;
  localparam logic [3:0] S_GROW2    = 4'd9;
  localparam logic [3:0] S_SCAN_RD  = 4'd10;
  localparam logic [3:0] S_SCAN_CK  = 4'd11;
  localparam logic [3:0] S_CARVE    = 4'd12;
  localparam logic [3:0] S_DONE     = 4'd13;

  logic [3:0]          state_r, state_nxt;
  logic [CLS_W-1:0]    cls_r, cls_nxt;
  logic [SIZE_W-1:0]   size_r, size_nxt;
  logic [CLS_W-1:0]    push_cls_r, push_cls_nxt;
  logic [ADDR_W-1:0]   push_addr_r, push_addr_nxt;
  logic                push_ret_r, push_ret_nxt;
  logic                borrow_r, borrow_nxt;
  logic                grown_r, grown_nxt;
  logic [REFILL_W-1:0] want_r, want_nxt;
  logic [REFILL_W-1:0] cnt_r, cnt_nxt;
  logic [REFILL_W-1:0] k_r, k_nxt;
  logic [POOL_W-1:0]   acc_r, acc_nxt;
  logic [POOL_W-1:0]   blk_r, blk_nxt;
  logic [POOL_W-1:0]   pool_start_r, pool_start_nxt;
  logic [POOL_W-1:0]   pool_end_r, pool_end_nxt;
  logic [POOL_W-1:0]   top_r, top_nxt;
  logic [CLS_W-1:0]    scan_r, scan_nxt;
  logic [ADDR_W-1:0]   head_r, head_nxt;
  logic [ADDR_W-1:0]   res_addr_r, res_addr_nxt;
  logic [1:0]          res_status_r, res_status_nxt;
  logic                out_valid_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic [1:0]          out_status_r;
  logic [REFILL_W-1:0] refill_r;

  logic [CLS_W-1:0]   head_rd_addr;
  logic [ADDR_W-1:0]  head_rd_data;
  logic [ADDR_W-1:0]  link_rd_data;
  heads_wr_t          head_wr;
  links_wr_t          link_wr;

  // request decode
  logic [ADDR_W-1:0] n_eff;
  logic [ADDR_W-1:0] cls_full;
  logic              is_large;
  logic [POOL_W-1:0] left;
  logic [GROW_W-1:0] grow_get;
  logic [GROW_W-1:0] share_q;
  logic [GROW_W-1:0] grow_end;
  logic [GROW_W-1:0] acc_next;
  logic              out_free;

  assign n_eff    = (in_req.request_bytes == '0) ? ADDR_W'(1) : in_req.request_bytes;
  assign cls_full = (n_eff - ADDR_W'(1)) >> ALIGN_W;
  assign is_large = (n_eff > ADDR_W'(MAX_SMALL_BYTES)) || (cls_full >= ADDR_W'(NUM_CLASSES));
  assign left     = pool_end_r - pool_start_r;
  assign share_q  = GROW_W'(top_r >> SHARE_SHIFT);
  assign grow_get = ((GROW_W'(size_r) * GROW_W'(want_r)) << 1)
                  + ((share_q + GROW_W'(ALIGN_BYTES - 1)) & ~GROW_W'(ALIGN_BYTES - 1));
  assign grow_end = GROW_W'(top_r) + grow_get;
  assign acc_next = GROW_W'(acc_r) + GROW_W'(size_r);
  assign out_free = !out_valid_r || out_rsp.ready;

  // memories
  sfla_heads u_heads (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (head_rd_addr),
    .rd_data (head_rd_data),
    .wr      (head_wr)
  );

  sfla_links u_links (
    .clk     (clk),
    .rd_addr (head_rd_data[ALIGN_W +: LINK_AW]),
    .rd_data (link_rd_data),
    .wr      (link_wr)
  );

  // head read address by state
  always_comb begin
    case (state_r)
      S_PUSH_RD: head_rd_addr = push_cls_r;
      S_SCAN_RD: head_rd_addr = scan_r;
      default:   head_rd_addr = cls_r;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cls_nxt        = cls_r;
    size_nxt       = size_r;
    push_cls_nxt   = push_cls_r;
    push_addr_nxt  = push_addr_r;
    push_ret_nxt   = push_ret_r;
    borrow_nxt     = borrow_r;
    grown_nxt      = grown_r;
    want_nxt       = want_r;
    cnt_nxt        = cnt_r;
    k_nxt          = k_r;
    acc_nxt        = acc_r;
    blk_nxt        = blk_r;
    pool_start_nxt = pool_start_r;
    pool_end_nxt   = pool_end_r;
    top_nxt        = top_r;
    scan_nxt       = scan_r;
    head_nxt       = head_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    head_wr        = '0;
    link_wr        = '0;

    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          cls_nxt      = cls_full[CLS_W-1:0];
          size_nxt     = SIZE_W'((cls_full + ADDR_W'(1)) << ALIGN_W);
          res_addr_nxt = '0;
          if (is_large) begin
            res_status_nxt = ST_LARGE;
            state_nxt      = S_DONE;
          end else if (in_req.operation == OP_RELEASE) begin
            push_cls_nxt  = cls_full[CLS_W-1:0];
            push_addr_nxt = {in_req.block_address[ADDR_W-1:ALIGN_W], {ALIGN_W{1'b0}}};
            push_ret_nxt  = 1'b0;
            state_nxt     = S_PUSH_RD;
          end else begin
            state_nxt = S_ALLOC_RD;
          end
        end
      end

      S_PUSH_RD: state_nxt = S_PUSH_WR;

      // link new block to old head, make it the head
      S_PUSH_WR: begin
        link_wr.en   = 1'b1;
        link_wr.addr = push_addr_r[ALIGN_W +: LINK_AW];
        link_wr.data = head_rd_data;
        head_wr.en   = 1'b1;
        head_wr.addr = push_cls_r;
        head_wr.data = push_addr_r;
        if (push_ret_r) begin
          state_nxt = S_GROW2;
        end else begin
          res_status_nxt = ST_RELEASED;
          state_nxt      = S_DONE;
        end
      end

      S_ALLOC_RD: state_nxt = S_ALLOC_CK;

      S_ALLOC_CK: begin
        if (head_rd_data != EMPTY_MARK) begin
          head_nxt   = head_rd_data;
          borrow_nxt = 1'b0;
          state_nxt  = S_POP_WR;
        end else begin
          if (refill_r == '0) begin
            want_nxt = REFILL_W'(1);
          end else if (refill_r > MAX_REFILL) begin
            want_nxt = MAX_REFILL;
          end else begin
            want_nxt = refill_r;
          end
          cnt_nxt   = '0;
          acc_nxt   = '0;
          grown_nxt = 1'b0;
          state_nxt = S_TAKE;
        end
      end

      // head takes the popped block's link
      S_POP_WR: begin
        head_wr.en   = 1'b1;
        head_wr.addr = borrow_r ? scan_r : cls_r;
        head_wr.data = link_rd_data;
        if (borrow_r) begin
          pool_start_nxt = POOL_W'(head_r);
          pool_end_nxt   = POOL_W'(head_r)
                         + POOL_W'((POOL_W'(scan_r) + POOL_W'(1)) << ALIGN_W);
          grown_nxt      = 1'b1;
          cnt_nxt        = '0;
          acc_nxt        = '0;
          state_nxt      = S_TAKE;
        end else begin
          res_addr_nxt   = head_r;
          res_status_nxt = ST_GRANTED;
          state_nxt      = S_DONE;
        end
      end

      // count blocks that fit, one block a cycle
      S_TAKE: begin
        if (cnt_r < want_r && acc_next <= GROW_W'(left)) begin
          acc_nxt = acc_next[POOL_W-1:0];
          cnt_nxt = cnt_r + REFILL_W'(1);
        end else begin
          state_nxt = S_TAKE_END;
        end
      end

      S_TAKE_END: begin
        if (cnt_r == '0) begin
          if (grown_r) begin
            res_status_nxt = ST_OOM;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_GROW;
          end
        end else begin
          pool_start_nxt = pool_start_r + acc_r;
          blk_nxt        = pool_start_r + POOL_W'(size_r);
          k_nxt          = REFILL_W'(1);
          res_addr_nxt   = pool_start_r[ADDR_W-1:0];
          res_status_nxt = ST_GRANTED;
          if (cnt_r > REFILL_W'(1)) begin
            head_wr.en   = 1'b1;
            head_wr.addr = cls_r;
            head_wr.data = blk_nxt[ADDR_W-1:0];
          end
          state_nxt = S_CARVE;
        end
      end

      // leftover pool bytes, if a whole aligned block, go back as one block
      S_GROW: begin
        pool_start_nxt = pool_end_r;
        if (left >= POOL_W'(ALIGN_BYTES)) begin
          push_cls_nxt  = CLS_W'((left >> ALIGN_W) - POOL_W'(1));
          push_addr_nxt = pool_start_r[ADDR_W-1:0];
          push_ret_nxt  = 1'b1;
          state_nxt     = S_PUSH_RD;
        end else begin
          state_nxt = S_GROW2;
        end
      end

      // bump the region, else borrow from this class or a larger one
      S_GROW2: begin
        if (grow_end <= GROW_W'(REGION_BYTES)) begin
          pool_start_nxt = top_r;
          pool_end_nxt   = grow_end[POOL_W-1:0];
          top_nxt        = grow_end[POOL_W-1:0];
          grown_nxt      = 1'b1;
          cnt_nxt        = '0;
          acc_nxt        = '0;
          state_nxt      = S_TAKE;
        end else begin
          scan_nxt  = cls_r;
          state_nxt = S_SCAN_RD;
        end
      end

      S_SCAN_RD: state_nxt = S_SCAN_CK;

      S_SCAN_CK: begin
        if (head_rd_data != EMPTY_MARK) begin
          head_nxt   = head_rd_data;
          borrow_nxt = 1'b1;
          state_nxt  = S_POP_WR;
        end else if (scan_r == CLS_W'(NUM_CLASSES - 1)) begin
          res_status_nxt = ST_OOM;
          state_nxt      = S_DONE;
        end else begin
          scan_nxt  = scan_r + CLS_W'(1);
          state_nxt = S_SCAN_RD;
        end
      end

      // thread carved blocks, one link a cycle
      S_CARVE: begin
        if (k_r == cnt_r) begin
          state_nxt = S_DONE;
        end else begin
          link_wr.en   = 1'b1;
          link_wr.addr = blk_r[ALIGN_W +: LINK_AW];
          link_wr.data = (k_r + REFILL_W'(1) == cnt_r) ? EMPTY_MARK
                       : ADDR_W'(blk_r + POOL_W'(size_r));
          blk_nxt      = blk_r + POOL_W'(size_r);
          k_nxt        = k_r + REFILL_W'(1);
        end
      end

      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control and pool state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pool_start_r <= '0;
      pool_end_r   <= '0;
      top_r        <= '0;
      refill_r     <= REFILL_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pool_start_r <= pool_start_nxt;
      pool_end_r   <= pool_end_nxt;
      top_r        <= top_nxt;
      if (cfg_wr.valid) begin
        refill_r <= cfg_wr.data;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    cls_r        <= cls_nxt;
    size_r       <= size_nxt;
    push_cls_r   <= push_cls_nxt;
    push_addr_r  <= push_addr_nxt;
    push_ret_r   <= push_ret_nxt;
    borrow_r     <= borrow_nxt;
    grown_r      <= grown_nxt;
    want_r       <= want_nxt;
    cnt_r        <= cnt_nxt;
    k_r          <= k_nxt;
    acc_r        <= acc_nxt;
    blk_r        <= blk_nxt;
    scan_r       <= scan_nxt;
    head_r       <= head_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    if (state_r == S_DONE && out_free) begin
      out_addr_r   <= res_addr_r;
      out_status_r <= res_status_r;
    end
  end

  assign in_req.ready            = (state_r == S_IDLE);
  assign cfg_wr.ready            = 1'b1;
  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.granted_address = out_addr_r;
  assign out_rsp.status          = out_status_r;

  // checks
  `SFLA_ASSERT(a_pool_order, pool_start_r <= pool_end_r, "pool start past pool end")
  `SFLA_ASSERT(a_region_bound, top_r <= POOL_W'(REGION_BYTES), "bump pointer past region")
  `SFLA_ASSERT(a_carve_bound, state_r != S_CARVE || k_r <= cnt_r, "carve index overrun")
  `SFLA_ASSERT(a_rsp_from_done, $rose(out_valid_r) |-> $past(state_r) == S_DONE, "stray beat")
  `SFLA_ASSERT_NEXT(a_take_ends, state_r == S_TAKE && cnt_r == want_r, state_r == S_TAKE_END, "take overrun")

endmodule

>>> hdl/sfla_heads.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfla_heads
// List-head memory, one entry per class, registered read, per-entry valid
// bits so unwritten heads read as the empty marker.
// ----------------------------------------------------------------------------
module sfla_heads (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [sfla_pkg::CLS_W-1:0]  rd_addr,
  output logic [sfla_pkg::ADDR_W-1:0] rd_data,
  input  sfla_pkg::heads_wr_t         wr
);
  import sfla_pkg::*;

  logic [ADDR_W-1:0]      mem [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] vld_r;
  logic [ADDR_W-1:0]      rd_data_r;

  // storage write
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  // registered read, write data forwarded on a same-entry hit
  always_ff @(posedge clk) begin
    if (wr.en && wr.addr == rd_addr) begin
      rd_data_r <= wr.data;
    end else if (vld_r[rd_addr]) begin
      rd_data_r <= mem[rd_addr];
    end else begin
      rd_data_r <= EMPTY_MARK;
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/sfla_links.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfla_links
// Link-word memory, one word per aligned block, one write and one
// registered read per cycle. No reset: entries are read only once written.
// ----------------------------------------------------------------------------
module sfla_links (
  input  logic                         clk,
  input  logic [sfla_pkg::LINK_AW-1:0] rd_addr,
  output logic [sfla_pkg::ADDR_W-1:0]  rd_data,
  input  sfla_pkg::links_wr_t          wr
);
  import sfla_pkg::*;

  logic [ADDR_W-1:0] mem [REGION_BYTES / ALIGN_BYTES];
  logic [ADDR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> tb/sfla_alloc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfla_alloc_checker
// Watches the request, config and response channels of the allocator,
// keeps its own copy of the free lists and chunk pool, and checks every
// response beat against the predicted grant address and status.
// ----------------------------------------------------------------------------
module sfla_alloc_checker (
  input  logic clk,
  input  logic rst_n,
  sfla_req_if  req,
  sfla_rsp_if  rsp,
  sfla_cfg_if  cfg,
  output int   fail_count,
  output int   pending
);
  import sfla_pkg::*;

  localparam int unsigned LINK_DEPTH = REGION_BYTES / ALIGN_BYTES;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [1:0]        status;
  } alloc_rsp_t;

  // allocator state mirror
  logic [ADDR_W-1:0]   heads [NUM_CLASSES];
  logic [ADDR_W-1:0]   links [LINK_DEPTH];
  int unsigned         pool_lo, pool_hi, bump_top, taken;
  logic [REFILL_W-1:0] refill;
  alloc_rsp_t          exp_rsp_q [$];
  int                  errs;

  function automatic void push_free(int unsigned cls, int unsigned a);
    links[(a / ALIGN_BYTES) % LINK_DEPTH] = heads[cls];
    heads[cls] = a[ADDR_W-1:0];
  endfunction

  function automatic int unsigned pop_free(int unsigned cls);
    int unsigned p;
    p = heads[cls];
    heads[cls] = links[(p / ALIGN_BYTES) % LINK_DEPTH];
    return p;
  endfunction

  // carve up to want blocks from the pool; returns how many
  function automatic int unsigned carve_pool(int unsigned size, int unsigned want,
                                             ref int unsigned first);
    int unsigned left, cnt;
    left = pool_hi - pool_lo;
    cnt  = (size * want <= left) ? want : left / size;
    if (cnt == 0) return 0;
    first = pool_lo;
    pool_lo += cnt * size;
    return cnt;
  endfunction

  function automatic bit grow_pool(int unsigned cls, int unsigned size, int unsigned want);
    int unsigned left, need;
    left = pool_hi - pool_lo;
    // leftover pool bytes, if a whole aligned block, go back as one block
    if (left >= ALIGN_BYTES) push_free(left / ALIGN_BYTES - 1, pool_lo);
    pool_lo = pool_hi;
    need = 2 * size * want + (((taken >> SHARE_SHIFT) + ALIGN_BYTES - 1) / ALIGN_BYTES)
           * ALIGN_BYTES;
    if (bump_top + need <= REGION_BYTES) begin
      pool_lo  = bump_top;
      bump_top += need;
      pool_hi  = bump_top;
      taken    += need;
      return 1'b1;
    end
    // borrow one block from this class or a larger one
    for (int unsigned c = cls; c < NUM_CLASSES; c++) begin
      if (heads[c] != EMPTY_MARK) begin
        pool_lo = pop_free(c);
        pool_hi = pool_lo + (c + 1) * ALIGN_BYTES;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic alloc_rsp_t serve_request(logic op, logic [ADDR_W-1:0] nbytes,
                                               logic [ADDR_W-1:0] baddr);
    alloc_rsp_t  r;
    int unsigned n, cls, size, want, first, cnt, blk;
    r = '0;
    first = 0;
    n = (nbytes == 0) ? 1 : nbytes;
    cls = (n + ALIGN_BYTES - 1) / ALIGN_BYTES - 1;
    if (n > MAX_SMALL_BYTES || cls >= NUM_CLASSES) begin
      r.status = ST_LARGE;
      return r;
    end
    size = (cls + 1) * ALIGN_BYTES;
    if (op == OP_RELEASE) begin
      push_free(cls, baddr - (baddr % ALIGN_BYTES));
      r.status = ST_RELEASED;
      return r;
    end
    if (heads[cls] != EMPTY_MARK) begin
      r.addr   = ADDR_W'(pop_free(cls));
      r.status = ST_GRANTED;
      return r;
    end
    want = (refill == 0) ? 1 : (refill > MAX_REFILL) ? MAX_REFILL : refill;
    cnt = carve_pool(size, want, first);
    if (cnt == 0) begin
      if (!grow_pool(cls, size, want)) begin
        r.status = ST_OOM;
        return r;
      end
      cnt = carve_pool(size, want, first);
      if (cnt == 0) begin
        r.status = ST_OOM;
        return r;
      end
    end
    // thread the extra blocks onto the class list
    for (int unsigned k = 1; k < cnt; k++) begin
      blk = first + k * size;
      links[(blk / ALIGN_BYTES) % LINK_DEPTH] =
        (k + 1 == cnt) ? EMPTY_MARK : ADDR_W'(blk + size);
    end
    if (cnt > 1) heads[cls] = ADDR_W'(first + size);
    r.addr   = ADDR_W'(first);
    r.status = ST_GRANTED;
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_rsp_t e;
    if (!rst_n) begin
      foreach (heads[i]) heads[i] = EMPTY_MARK;
      foreach (links[i]) links[i] = '0;
      pool_lo  = 0;
      pool_hi  = 0;
      bump_top = 0;
      taken    = 0;
      refill   = REFILL_RESET;
      exp_rsp_q.delete();
      errs     = 0;
    end else begin
      // response beat vs oldest prediction
      if (rsp.valid && rsp.ready) begin
        if (exp_rsp_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: unexpected response addr=%h status=%0d",
                     $realtime, rsp.granted_address, rsp.status);
        end else begin
          e = exp_rsp_q.pop_front();
          if (rsp.status !== e.status) begin
            errs++;
            if (errs <= 10)
              $display("%0t: status mismatch exp=%0d got=%0d", $realtime, e.status,
                       rsp.status);
          end
          if (rsp.granted_address !== e.addr) begin
            errs++;
            if (errs <= 10)
              $display("%0t: address mismatch exp=%h got=%h", $realtime, e.addr,
                       rsp.granted_address);
          end
        end
      end
      if (cfg.valid && cfg.ready) refill = cfg.data;
      if (req.valid && req.ready)
        exp_rsp_q.push_back(serve_request(req.operation, req.request_bytes,
                                          req.block_address));
    end
    fail_count <= errs;
    pending    <= exp_rsp_q.size();
  end

endmodule

>>> tb/tb_segregated_free_list_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segregated_free_list_allocator
// Drives directed and random allocate/release traffic through the allocator
// under several refill settings, with random gaps and back-pressure, and
// reports the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module tb_segregated_free_list_allocator;
  import sfla_pkg::*;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    int unsigned       cls;
  } held_blk_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic calm = 1'b0;
  int   chk_fails, chk_pending;
  int   idle_cycles = 0;
  int   n_items = 0, n_grant = 0, n_rel = 0, n_large = 0, n_oom = 0;
  logic [ADDR_W-1:0] sent_bytes_q [$];
  held_blk_t         held_q [$];

  sfla_req_if req_ch ();
  sfla_rsp_if rsp_ch ();
  sfla_cfg_if cfg_ch ();

  segregated_free_list_allocator dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch),
    .cfg_wr  (cfg_ch)
  );

  sfla_alloc_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg        (cfg_ch),
    .fail_count (chk_fails),
    .pending    (chk_pending)
  );

  always #2 clk = ~clk;

  // response back-pressure
  always @(posedge clk) begin
    rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 29);
  end

  // track granted blocks so releases can return real ones
  always @(posedge clk) begin
    logic [ADDR_W-1:0] nb;
    held_blk_t         h;
    if (rst_n && rsp_ch.valid && rsp_ch.ready && sent_bytes_q.size() > 0) begin
      nb = sent_bytes_q.pop_front();
      case (rsp_ch.status)
        ST_GRANTED: begin
          n_grant++;
          h.addr = rsp_ch.granted_address;
          h.cls  = (nb == 0) ? 0 : (nb + ALIGN_BYTES - 1) / ALIGN_BYTES - 1;
          held_q.push_back(h);
        end
        ST_RELEASED: n_rel++;
        ST_LARGE:    n_large++;
        default:     n_oom++;
      endcase
    end
  end

  // watchdog: cycles without any beat
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles > 20000) begin
      $display("tb_segregated_free_list_allocator NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic put_item(logic op, logic [ADDR_W-1:0] nb, logic [ADDR_W-1:0] ba);
    while (!calm && $urandom_range(99) < 29) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.operation     <= op;
    req_ch.request_bytes <= nb;
    req_ch.block_address <= ba;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent_bytes_q.push_back(nb);
    n_items++;
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
  endtask

  task automatic write_refill(logic [REFILL_W-1:0] v);
    drain_results();
    // quiet gap before the register changes
    repeat (150) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_item(int alloc_pct);
    int        r, idx;
    held_blk_t h;
    logic [ADDR_W-1:0] ba;
    r = $urandom_range(99);
    if (r < alloc_pct) begin
      put_item(OP_ALLOC, ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom_range(1, 128)),
               16'($urandom));
    end else if (r < 94 && held_q.size() > 0) begin
      idx = $urandom_range(held_q.size() - 1);
      h = held_q[idx];
      held_q.delete(idx);
      ba = h.addr | (($urandom_range(3) == 0) ? 16'($urandom_range(7)) : 16'd0);
      put_item(OP_RELEASE, 16'(h.cls * ALIGN_BYTES + $urandom_range(1, ALIGN_BYTES)), ba);
    end else begin
      // noise: any size, any address, either operation
      put_item(1'($urandom), $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(136)),
               16'($urandom));
    end
  endtask

  initial begin
    int                  phase_pct [6];
    logic [REFILL_W-1:0] phase_refill [6];
    req_ch.valid = 1'b0;
    req_ch.operation = OP_ALLOC;
    req_ch.request_bytes = '0;
    req_ch.block_address = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    rsp_ch.ready = 1'b0;
    phase_pct = '{60, 85, 50, 55, 60, 60};
    phase_refill = '{6'd1, 6'd32, 6'd0, 6'd63, 6'($urandom_range(2, 31)), 6'd20};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: sizes at the edges, large, zero, misaligned and top-of-space
    put_item(OP_ALLOC,   16'd1,     16'h0000);
    put_item(OP_ALLOC,   16'd0,     16'hFFFF);
    put_item(OP_ALLOC,   16'd128,   16'h0000);
    put_item(OP_ALLOC,   16'd129,   16'h0000);
    put_item(OP_ALLOC,   16'hFFFF,  16'hFFFF);
    put_item(OP_RELEASE, 16'd200,   16'h0040);
    put_item(OP_RELEASE, 16'd8,     16'h0013);
    put_item(OP_ALLOC,   16'd8,     16'h0000);
    put_item(OP_RELEASE, 16'd128,   16'hFFFF);
    put_item(OP_ALLOC,   16'd121,   16'h0000);
    put_item(OP_ALLOC,   16'd64,    16'h0000);
    put_item(OP_RELEASE, 16'd64,    16'h1234);
    put_item(OP_ALLOC,   16'd57,    16'h0000);
    put_item(OP_ALLOC,   16'd72,    16'h0000);
    put_item(OP_RELEASE, 16'd0,     16'h0008);
    put_item(OP_ALLOC,   16'd1,     16'h0000);
    put_item(OP_RELEASE, 16'h8000,  16'h8000);

    // random phases, one refill setting each
    for (int p = 0; p < 6; p++) begin
      write_refill(phase_refill[p]);
      for (int i = 0; i < 305; i++) begin
        calm = (p == 1 && i >= 100 && i < 250);
        if (p == 2 && i == 150) drain_results();
        random_item(phase_pct[p]);
      end
      calm = 1'b0;
    end

    drain_results();
    repeat (150) @(posedge clk);
    $display("Covered %0d requests over six refill settings: %0d grants, %0d releases,",
             n_items, n_grant, n_rel);
    $display("%0d large forwards and %0d out-of-memory responses.", n_large, n_oom);
    if (chk_fails == 0 && chk_pending == 0) begin
      $display("tb_segregated_free_list_allocator OK");
    end else begin
      $display("tb_segregated_free_list_allocator NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/sfla_pkg.sv
hdl/sfla_if.sv
hdl/sfla_heads.sv
hdl/sfla_links.sv
hdl/segregated_free_list_allocator.sv
tb/sfla_alloc_checker.sv
tb/tb_segregated_free_list_allocator.sv
